FILE: src/kpl_pkg.sv
// Shared types and constants for the keypad code lock.
`timescale 1ns / 1ps

package kpl_pkg;

    localparam int CODE_W          = 14;
    localparam int CODE_DIGITS     = 4;
    localparam int TABLE_DEPTH_DEF = 256;

    // v / 10 == (v * 52429) >> 19 for every v below 43690
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_DELETE    = 4'd10;
    localparam logic [3:0] KEY_CANCEL    = 4'd11;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_NONE       = 3'd0,
        RES_UNLOCKED   = 3'd1,
        RES_REJECTED   = 3'd2,
        RES_LEFT       = 3'd3,
        RES_TABLE_OK   = 3'd4,
        RES_TABLE_FULL = 3'd5,
        RES_BAD_INDEX  = 3'd6
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_WRITE,
        S_EMIT
    } state_t;

    // control for one step of the code ring
    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [CODE_W-1:0] data;
    } ring_ctl_t;

endpackage

FILE: src/kpl_if.sv
// Handshake interfaces for the item and result channels.
`timescale 1ns / 1ps

interface kpl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  key;
    logic [13:0] entry_code;
    logic [7:0]  entry_index;

    modport source (output valid, op, key, entry_code, entry_index, input ready);
    modport sink   (input valid, op, key, entry_code, entry_index, output ready);
endinterface

interface kpl_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [2:0] digits_entered;
    logic [8:0] stored_count;
    logic [7:0] written_index;

    modport source (output valid, event_res, digits_entered, stored_count, written_index,
                    input ready);
    modport sink   (input valid, event_res, digits_entered, stored_count, written_index,
                    output ready);
endinterface

FILE: src/keypad_code_lock_with_code_table_unit.sv
// Keypad code lock top level: entry logic, table sequencer and result register.
//
//   channel  | role | fields
//   ---------+------+---------------------------------------------------------
//   item     | sink | op, key, entry_code, entry_index
//   result   | src  | event_res, digits_entered, stored_count, written_index
//
// Keys that do not complete a code, clear and bad requests go from idle to emit.
// A fourth digit scans and an append writes while the code ring makes one full
// turn past its head cell. A delete that moves an entry makes two turns: one to
// fetch the last entry, one to write it into the freed slot.
// Reset clears the control state only; table cells are read only below the count.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module keypad_code_lock_with_code_table_unit #(
    parameter int TABLE_DEPTH = kpl_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    kpl_item_if.sink           item,
    kpl_result_if.source       result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(TABLE_DEPTH - 1);

    kpl_pkg::state_t             state_reg,   state_next;
    logic [IDX_W-1:0]            step_reg,    step_next;
    logic [IDX_W-1:0]            slot_reg,    slot_next;
    logic [IDX_W-1:0]            tgt_reg,     tgt_next;
    logic [kpl_pkg::CODE_W-1:0]  val_reg,     val_next;
    logic                        hit_reg,     hit_next;
    kpl_pkg::res_t               res_reg,     res_next;
    logic [7:0]                  written_reg, written_next;
    logic [CNT_W-1:0]            count_reg,   count_next;
    logic [kpl_pkg::CODE_W-1:0]  entered_reg, entered_next;
    logic [2:0]                  digits_reg,  digits_next;

    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  out_res_reg,   out_res_next;
    logic [2:0]                  out_digits_reg, out_digits_next;
    logic [8:0]                  out_count_reg, out_count_next;
    logic [7:0]                  out_written_reg, out_written_next;

    kpl_pkg::ring_ctl_t          ring_ctl;
    logic [kpl_pkg::CODE_W-1:0]  head;

    logic [17:0]                 times_ten;
    logic [kpl_pkg::CODE_W-1:0]  shifted_val;
    logic [2:0]                  shifted_digits;
    logic [30:0]                 div_prod;
    logic [kpl_pkg::CODE_W-1:0]  tenth_val;
    logic                        match;
    logic                        step_at_last;
    kpl_pkg::op_t                item_op;

    kpl_ring #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ring (
        .clk  (clk),
        .ctl  (ring_ctl),
        .head (head)
    );

    assign item_op = kpl_pkg::op_t'(item.op);

    // entered * 10 + digit, kept to the code width
    assign times_ten   = {1'b0, entered_reg, 3'b000} + {3'b000, entered_reg, 1'b0}
                         + {14'd0, item.key};
    assign shifted_val = times_ten[kpl_pkg::CODE_W-1:0];
    // leading zeros are not counted
    assign shifted_digits = (shifted_val == '0) ? 3'd0 : digits_reg + 3'd1;

    assign div_prod  = 31'(entered_reg) * 31'(kpl_pkg::DIV10_MUL);
    assign tenth_val = kpl_pkg::CODE_W'(div_prod[30:kpl_pkg::DIV10_SHIFT]);

    assign match        = (CNT_W'(step_reg) < count_reg) && (head == val_reg);
    assign step_at_last = (step_reg == STEP_LAST);

    assign item.ready            = (state_reg == kpl_pkg::S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.event_res      = out_res_reg;
    assign result.digits_entered = out_digits_reg;
    assign result.stored_count   = out_count_reg;
    assign result.written_index  = out_written_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpl_pkg::S_IDLE;
            count_reg     <= '0;
            entered_reg   <= '0;
            digits_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            entered_reg   <= entered_next;
            digits_reg    <= digits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        slot_reg        <= slot_next;
        tgt_reg         <= tgt_next;
        val_reg         <= val_next;
        hit_reg         <= hit_next;
        res_reg         <= res_next;
        written_reg     <= written_next;
        out_res_reg     <= out_res_next;
        out_digits_reg  <= out_digits_next;
        out_count_reg   <= out_count_next;
        out_written_reg <= out_written_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        slot_next        = slot_reg;
        tgt_next         = tgt_reg;
        val_next         = val_reg;
        hit_next         = hit_reg;
        res_next         = res_reg;
        written_next     = written_reg;
        count_next       = count_reg;
        entered_next     = entered_reg;
        digits_next      = digits_reg;
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;
        out_digits_next  = out_digits_reg;
        out_count_next   = out_count_reg;
        out_written_next = out_written_reg;
        ring_ctl.shift   = 1'b0;
        ring_ctl.wr      = 1'b0;
        ring_ctl.data    = val_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            kpl_pkg::S_IDLE:
            begin
                if (item.valid)
                begin
                    step_next    = '0;
                    hit_next     = 1'b0;
                    written_next = '0;
                    res_next     = kpl_pkg::RES_NONE;
                    state_next   = kpl_pkg::S_EMIT;
                    case (item_op)
                        kpl_pkg::OP_KEY:
                        begin
                            if (item.key inside {[4'd0:kpl_pkg::KEY_DIGIT_MAX]})
                            begin
                                if (shifted_digits == 3'(kpl_pkg::CODE_DIGITS))
                                begin
                                    val_next     = shifted_val;
                                    entered_next = '0;
                                    digits_next  = '0;
                                    state_next   = kpl_pkg::S_SCAN;
                                end
                                else
                                begin
                                    entered_next = shifted_val;
                                    digits_next  = shifted_digits;
                                end
                            end
                            else if (item.key == kpl_pkg::KEY_DELETE)
                            begin
                                if (digits_reg != '0)
                                begin
                                    digits_next  = digits_reg - 3'd1;
                                    entered_next = tenth_val;
                                end
                                else
                                begin
                                    entered_next = '0;
                                    digits_next  = '0;
                                    res_next     = kpl_pkg::RES_LEFT;
                                end
                            end
                            else if (item.key == kpl_pkg::KEY_CANCEL)
                            begin
                                entered_next = '0;
                                digits_next  = '0;
                                res_next     = kpl_pkg::RES_LEFT;
                            end
                        end
                        kpl_pkg::OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                slot_next    = IDX_W'(count_reg);
                                val_next     = item.entry_code;
                                written_next = 8'(count_reg);
                                count_next   = count_reg + CNT_W'(1);
                                res_next     = kpl_pkg::RES_TABLE_OK;
                                state_next   = kpl_pkg::S_WRITE;
                            end
                            else
                            begin
                                res_next = kpl_pkg::RES_TABLE_FULL;
                            end
                        end
                        kpl_pkg::OP_DELETE:
                        begin
                            if (CMP_W'(item.entry_index) < CMP_W'(count_reg))
                            begin
                                count_next = count_reg - CNT_W'(1);
                                res_next   = kpl_pkg::RES_TABLE_OK;
                                // fill the hole with the last entry
                                if (CMP_W'(item.entry_index) != CMP_W'(count_reg - CNT_W'(1)))
                                begin
                                    slot_next  = IDX_W'(count_reg - CNT_W'(1));
                                    tgt_next   = IDX_W'(item.entry_index);
                                    state_next = kpl_pkg::S_FETCH;
                                end
                            end
                            else
                            begin
                                res_next = kpl_pkg::RES_BAD_INDEX;
                            end
                        end
                        kpl_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            res_next   = kpl_pkg::RES_TABLE_OK;
                        end
                        default:
                        begin
                            res_next = kpl_pkg::RES_NONE;
                        end
                    endcase
                end
            end

            kpl_pkg::S_SCAN:
            begin
                ring_ctl.shift = 1'b1;
                step_next      = step_reg + IDX_W'(1);
                if (match)
                begin
                    hit_next = 1'b1;
                end
                if (step_at_last)
                begin
                    step_next  = '0;
                    res_next   = (hit_reg || match) ? kpl_pkg::RES_UNLOCKED
                                                    : kpl_pkg::RES_REJECTED;
                    state_next = kpl_pkg::S_EMIT;
                end
            end

            kpl_pkg::S_FETCH:
            begin
                ring_ctl.shift = 1'b1;
                step_next      = step_reg + IDX_W'(1);
                if (step_reg == slot_reg)
                begin
                    val_next = head;
                end
                if (step_at_last)
                begin
                    step_next  = '0;
                    slot_next  = tgt_reg;
                    state_next = kpl_pkg::S_WRITE;
                end
            end

            kpl_pkg::S_WRITE:
            begin
                ring_ctl.shift = 1'b1;
                ring_ctl.wr    = (step_reg == slot_reg);
                step_next      = step_reg + IDX_W'(1);
                if (step_at_last)
                begin
                    step_next  = '0;
                    state_next = kpl_pkg::S_EMIT;
                end
            end

            kpl_pkg::S_EMIT:
            begin
                // hold until the output register is free or draining
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_res_next     = res_reg;
                    out_digits_next  = digits_reg;
                    out_count_next   = 9'(count_reg);
                    out_written_next = written_reg;
                    state_next       = kpl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kpl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/kpl_cell.sv
// One cell of the code ring: holds one stored code, loads from its neighbor.
`timescale 1ns / 1ps

module kpl_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [kpl_pkg::CODE_W-1:0]  d,
    output logic [kpl_pkg::CODE_W-1:0]  q
);

    logic [kpl_pkg::CODE_W-1:0] code_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            code_reg <= d;
        end
    end

    assign q = code_reg;

endmodule

FILE: src/kpl_ring.sv
// Ring of code cells; cell 0 is the head, the tail takes the head or new data.
`timescale 1ns / 1ps

module kpl_ring #(
    parameter int TABLE_DEPTH = kpl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  kpl_pkg::ring_ctl_t          ctl,
    output logic [kpl_pkg::CODE_W-1:0]  head
);

    logic [kpl_pkg::CODE_W-1:0] cell_q [TABLE_DEPTH];
    logic [kpl_pkg::CODE_W-1:0] tail_d;

    // rewrite the entry passing the head, or recirculate it
    assign tail_d = ctl.wr ? ctl.data : cell_q[0];
    assign head   = cell_q[0];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [kpl_pkg::CODE_W-1:0] d;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign d = tail_d;
        end
        else
        begin : g_body
            assign d = cell_q[i+1];
        end

        kpl_cell u_cell (
            .clk   (clk),
            .shift (ctl.shift),
            .d     (d),
            .q     (cell_q[i])
        );
    end

endmodule

FILE: tb/tb_keypad_code_lock_with_code_table_unit.sv
// Testbench for the keypad code lock: directed and random transactions checked against a predictor.
`timescale 1ns / 1ps

module tb_keypad_code_lock_with_code_table_unit;
    import kpl_pkg::*;

    localparam int          TABLE_SLOTS    = TABLE_DEPTH_DEF;
    localparam int unsigned CODE_MASK      = (1 << CODE_W) - 1;
    localparam int          IDLE_LIMIT     = 4000;
    localparam int          DRAIN_CYCLES   = 2 * TABLE_SLOTS + 100;
    localparam int          RANDOM_ITEMS   = 1100;
    localparam logic [3:0]  KEY_UNUSED_LO  = 4'd12;
    localparam logic [3:0]  KEY_UNUSED_HI  = 4'd15;

    typedef struct {
        res_t       ev;
        logic [2:0] digits;
        logic [8:0] stored;
        logic [7:0] slot;
    } lock_result_t;

    // Tracks table and keypad entry, queues the answer owed for each accepted transaction.
    class lock_tracker;
        logic [CODE_W-1:0] codes [TABLE_SLOTS];
        int unsigned       stored;
        int unsigned       entered;
        int unsigned       digits;
        lock_result_t      owed[$];
        int unsigned       errors;

        function bit code_stored(int unsigned value);
            for (int i = 0; i < stored; i++)
                if (codes[i] == value)
                    return 1'b1;
            return 1'b0;
        endfunction

        function res_t press_key(logic [3:0] k);
            bit hit;
            if (k <= KEY_DIGIT_MAX)
            begin
                if (digits < CODE_DIGITS)
                begin
                    entered = (entered * 10 + k) & CODE_MASK;
                    digits++;
                end
                // leading zeros do not count as digits
                if (entered == 0)
                    digits = 0;
                if (digits < CODE_DIGITS)
                    return RES_NONE;
                hit = code_stored(entered);
                entered = 0;
                digits = 0;
                return hit ? RES_UNLOCKED : RES_REJECTED;
            end
            if (k == KEY_DELETE && digits > 0)
            begin
                digits--;
                entered /= 10;
                return RES_NONE;
            end
            if (k == KEY_DELETE || k == KEY_CANCEL)
            begin
                entered = 0;
                digits = 0;
                return RES_LEFT;
            end
            return RES_NONE;
        endfunction

        function void take_item(op_t op, logic [3:0] k, logic [13:0] code, logic [7:0] idx);
            lock_result_t r;
            r.ev   = RES_NONE;
            r.slot = '0;
            case (op)
                OP_KEY:
                    r.ev = press_key(k);
                OP_APPEND:
                    if (stored < TABLE_SLOTS)
                    begin
                        codes[stored] = code;
                        r.slot = 8'(stored);
                        stored++;
                        r.ev = RES_TABLE_OK;
                    end
                    else
                        r.ev = RES_TABLE_FULL;
                OP_DELETE:
                    if (idx < stored)
                    begin
                        // move the last entry into the freed slot
                        stored--;
                        if (idx != stored)
                            codes[idx] = codes[stored];
                        r.ev = RES_TABLE_OK;
                    end
                    else
                        r.ev = RES_BAD_INDEX;
                default:
                begin
                    stored = 0;
                    r.ev = RES_TABLE_OK;
                end
            endcase
            r.digits = 3'(digits);
            r.stored = 9'(stored);
            owed.push_back(r);
        endfunction

        function void check_result(logic [2:0] ev, logic [2:0] dg, logic [8:0] cnt,
                                   logic [7:0] slot);
            lock_result_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected result transaction: event_res %0d", ev);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (ev !== want.ev)
            begin
                $error("event_res: expected %0d, got %0d", want.ev, ev);
                errors++;
            end
            if (dg !== want.digits)
            begin
                $error("digits_entered: expected %0d, got %0d", want.digits, dg);
                errors++;
            end
            if (cnt !== want.stored)
            begin
                $error("stored_count: expected %0d, got %0d", want.stored, cnt);
                errors++;
            end
            if (slot !== want.slot)
            begin
                $error("written_index: expected %0d, got %0d", want.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n = 1'b0;
    int            src_idle_pct = 17;
    int            snk_idle_pct = 69;
    int unsigned   sent_items = 0;
    lock_tracker   tracker = new();

    kpl_item_if    item();
    kpl_result_if  result();

    keypad_code_lock_with_code_table_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_item(op_t op, logic [3:0] k, logic [13:0] code, logic [7:0] idx);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid       <= 1'b1;
        item.op          <= op;
        item.key         <= k;
        item.entry_code  <= code;
        item.entry_index <= idx;
        @(posedge clk);
        while (item.ready !== 1'b1)
            @(posedge clk);
        tracker.take_item(op, k, code, idx);
        sent_items++;
        @(negedge clk);
    endtask

    // unused fields carry random bits
    task automatic press(logic [3:0] k);
        send_item(OP_KEY, k, 14'($urandom), 8'($urandom));
    endtask

    task automatic append_code(logic [13:0] code);
        send_item(OP_APPEND, 4'($urandom), code, 8'($urandom));
    endtask

    task automatic remove_slot(logic [7:0] idx);
        send_item(OP_DELETE, 4'($urandom), 14'($urandom), idx);
    endtask

    task automatic enter_code(int unsigned code);
        press(4'(code / 1000));
        press(4'(code / 100 % 10));
        press(4'(code / 10 % 10));
        press(4'(code % 10));
    endtask

    // clean entry, optional leading zeros, then a stored code where one can be typed
    task automatic enter_stored();
        int unsigned code;
        code = $urandom_range(1000, 9999);
        if (tracker.stored > 0 && $urandom_range(0, 3) != 0)
            code = tracker.codes[$urandom_range(0, tracker.stored - 1)];
        if (code < 1000 || code > 9999)
            code = $urandom_range(1000, 9999);
        if (tracker.digits != 0)
            press(KEY_CANCEL);
        repeat ($urandom_range(0, 2))
            press(4'd0);
        enter_code(code);
    endtask

    // partial entry, back up with the delete key, finish with random digits
    task automatic enter_edited();
        int n;
        n = $urandom_range(1, 3);
        if (tracker.digits != 0)
            press(KEY_CANCEL);
        press(4'($urandom_range(1, 9)));
        repeat (n - 1)
            press(4'($urandom_range(0, 9)));
        repeat ($urandom_range(1, 2))
            press(KEY_DELETE);
        while (tracker.digits != 0)
            press(4'($urandom_range(0, 9)));
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            enter_stored();
        else if (r < 45)
            enter_edited();
        else if (r < 62)
        begin
            if ($urandom_range(0, 9) == 0)
                append_code(14'($urandom));
            else
                append_code(14'($urandom_range(1000, 9999)));
        end
        else if (r < 77)
        begin
            if (tracker.stored > 0 && $urandom_range(0, 4) != 0)
                remove_slot(8'($urandom_range(0, tracker.stored - 1)));
            else
                remove_slot(8'($urandom));
        end
        else if (r < 80)
            send_item(OP_CLEAR, 4'($urandom), 14'($urandom), 8'($urandom));
        else if (r < 85)
            press($urandom_range(0, 1) ? KEY_CANCEL : KEY_DELETE);
        else
            send_item(op_t'($urandom_range(0, 3)), 4'($urandom), 14'($urandom),
                      8'($urandom));
    endtask

    // result side: random stalls, check at every accepted transaction
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && result.valid === 1'b1 && result.ready === 1'b1)
            tracker.check_result(result.event_res, result.digits_entered,
                                 result.stored_count, result.written_index);

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item.valid === 1'b1 && item.ready === 1'b1) ||
                (result.valid === 1'b1 && result.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        item.valid       = 1'b0;
        item.op          = OP_KEY;
        item.key         = '0;
        item.entry_code  = '0;
        item.entry_index = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ignored keys, leaving entry, edge codes, unlock paths, table errors
        press(KEY_UNUSED_LO);
        press(KEY_UNUSED_HI);
        press(KEY_CANCEL);
        press(KEY_DELETE);
        append_code(14'd9999);
        append_code(14'h3FFF);
        append_code(14'd0);
        append_code(14'd1000);
        press(4'd0);
        press(4'd0);
        enter_code(9999);
        press(4'd1);
        press(4'd2);
        press(KEY_DELETE);
        press(4'd0);
        press(4'd0);
        press(4'd0);
        press(4'd5);
        append_code(14'd1234);
        press(KEY_CANCEL);
        enter_code(4321);
        remove_slot(8'd255);
        remove_slot(8'd1);
        send_item(OP_CLEAR, 4'd0, 14'd0, 8'd0);

        while (sent_items < RANDOM_ITEMS / 3)
            random_step();

        src_idle_pct = 69;
        snk_idle_pct = 17;
        while (sent_items < 2 * RANDOM_ITEMS / 3)
            random_step();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        // fill the table, overflow it, then work with high slots
        while (tracker.stored < TABLE_SLOTS)
            append_code(14'($urandom_range(1000, 9999)));
        repeat (3)
            append_code(14'($urandom));
        repeat (4)
            enter_stored();
        remove_slot(8'd255);
        remove_slot(8'($urandom_range(128, 254)));
        while (sent_items < RANDOM_ITEMS)
            random_step();

        item.valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
